@@ sv/mfu_pkg.sv @@
// Package for the MFU page replacement block: field widths, counter limits,
// the result beat type and the config reset value. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mfu_pkg;

    localparam int PAGE_W   = 16;
    localparam int FRAME_W  = 4;
    localparam int COUNT_W  = 16;
    localparam int CFG_W    = 5;
    localparam int GRP_SIZE = 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [CFG_W-1:0]   CFG_RESET = 5'd16;

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame_index;
        logic               evicted_valid;
        logic [PAGE_W-1:0]  evicted_page;
        logic [COUNT_W-1:0] use_count;
        logic [COUNT_W-1:0] fault_total;
    } rsp_t;

endpackage

`default_nettype wire

@@ sv/mfu_if.sv @@
// Handshake channels of the MFU block: page requests, results, config writes.
// Depends on mfu_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface mfu_req_if import mfu_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [PAGE_W-1:0] page_number;

    modport source (output valid, output page_number, input ready);
    modport sink   (input valid, input page_number, output ready);
endinterface

interface mfu_rsp_if import mfu_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               hit;
    logic [FRAME_W-1:0] frame_index;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [COUNT_W-1:0] use_count;
    logic [COUNT_W-1:0] fault_total;

    modport source (output valid, output hit, output frame_index, output evicted_valid,
                    output evicted_page, output use_count, output fault_total,
                    input ready);
    modport sink   (input valid, input hit, input frame_index, input evicted_valid,
                    input evicted_page, input use_count, input fault_total,
                    output ready);
endinterface

interface mfu_cfg_if import mfu_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] frames_in_use;

    modport source (output valid, output frames_in_use, input ready);
    modport sink   (input valid, input frames_in_use, output ready);
endinterface

`default_nettype wire

@@ sv/mfu_front.sv @@
// Front end: accepts request beats, sizes the page to the stored width and
// queues up to two of them for the back end. Depends on mfu_pkg, mfu_if.
`timescale 1ns / 1ps
`default_nettype none

module mfu_front import mfu_pkg::*; #(
    parameter int PAGE_BITS = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    mfu_req_if.sink                   req,
    output logic                      q_valid,
    output logic [PAGE_BITS-1:0]      q_page,
    input  wire logic                 q_pop
);

    logic [PAGE_BITS-1:0] slot_reg [2];
    logic                 wr_ptr_reg;
    logic                 rd_ptr_reg;
    logic [1:0]           cnt_reg;
    logic [1:0]           cnt_next;
    logic                 push;
    logic                 pop;
    logic [PAGE_BITS-1:0] page_in;

    always_comb
    begin
        if (PAGE_BITS > PAGE_W)
        begin
            page_in = PAGE_BITS'(req.page_number);
        end
        else
        begin
            page_in = req.page_number[PAGE_BITS-1:0];
        end
    end

    assign req.ready = (cnt_reg != 2'd2);
    assign push      = req.valid && req.ready;
    assign pop       = q_pop && q_valid;
    assign q_valid   = (cnt_reg != 2'd0);
    assign q_page    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= page_in;
        end
    end

endmodule

`default_nettype wire

@@ sv/mfu_back.sv @@
// Back end: frame table, two-step lookup / replacement sequencer, fault
// counter, config register and result register. Depends on mfu_pkg, mfu_if.
`timescale 1ns / 1ps
`default_nettype none

module mfu_back import mfu_pkg::*; #(
    parameter int NUM_FRAMES = 16,
    parameter int PAGE_BITS  = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_valid,
    input  wire logic [PAGE_BITS-1:0] q_page,
    output logic                      q_pop,
    mfu_cfg_if.sink                   cfg,
    mfu_rsp_if.source                 rsp
);

    localparam int IDX_W   = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int LIM_W   = ($clog2(NUM_FRAMES + 1) > CFG_W) ? $clog2(NUM_FRAMES + 1) : CFG_W;
    localparam int NUM_GRP = (NUM_FRAMES + GRP_SIZE - 1) / GRP_SIZE;

    localparam logic ST_LOOK = 1'b0;
    localparam logic ST_DO   = 1'b1;

    logic                 state_reg;
    logic [CFG_W-1:0]     cfg_reg;
    logic [NUM_FRAMES-1:0] fvalid_reg;
    logic [PAGE_BITS-1:0] fpage_reg [NUM_FRAMES];
    logic [COUNT_W-1:0]   fuses_reg [NUM_FRAMES];
    logic [COUNT_W-1:0]   fault_reg;
    logic [COUNT_W-1:0]   fault_next;

    logic [PAGE_BITS-1:0] req_page_reg;
    logic                 hit_reg;
    logic [IDX_W-1:0]     hit_idx_reg;
    logic [COUNT_W-1:0]   hit_cnt_reg;
    logic                 empty_any_reg;
    logic [IDX_W-1:0]     empty_idx_reg;
    logic                 grp_ok_reg   [NUM_GRP];
    logic [IDX_W-1:0]     grp_idx_reg  [NUM_GRP];
    logic [COUNT_W-1:0]   grp_cnt_reg  [NUM_GRP];
    logic [PAGE_BITS-1:0] grp_page_reg [NUM_GRP];

    logic                 out_valid_reg;
    rsp_t                 out_reg;
    rsp_t                 out_next;

    logic [LIM_W-1:0]     lim;
    logic [LIM_W-1:0]     cfg_ext;
    logic [NUM_FRAMES-1:0] managed;
    logic [NUM_FRAMES-1:0] match;
    logic [NUM_FRAMES-1:0] empty;
    logic                 hit_any;
    logic [IDX_W-1:0]     hit_idx;
    logic                 empty_any;
    logic [IDX_W-1:0]     empty_idx;
    logic                 grp_ok   [NUM_GRP];
    logic [IDX_W-1:0]     grp_idx  [NUM_GRP];
    logic [COUNT_W-1:0]   grp_cnt  [NUM_GRP];
    logic [PAGE_BITS-1:0] grp_page [NUM_GRP];

    logic                 best_ok;
    logic [IDX_W-1:0]     victim_idx;
    logic [COUNT_W-1:0]   best_cnt;
    logic [PAGE_BITS-1:0] victim_page;
    logic [IDX_W-1:0]     sel;
    logic [COUNT_W-1:0]   cnt_inc;
    logic                 evict;
    logic                 look;
    logic                 commit;

    assign cfg.ready = 1'b1;
    assign cfg_ext   = LIM_W'(cfg_reg);

    always_comb
    begin
        if (cfg_ext == '0)
        begin
            lim = LIM_W'(1);
        end
        else if (cfg_ext > LIM_W'(NUM_FRAMES))
        begin
            lim = LIM_W'(NUM_FRAMES);
        end
        else
        begin
            lim = cfg_ext;
        end
    end

    // lookup step: parallel compare, first hit / first empty, per-group max
    always_comb
    begin
        int k;
        for (int i = 0; i < NUM_FRAMES; i++)
        begin
            managed[i] = (LIM_W'(i) < lim);
            match[i]   = managed[i] && fvalid_reg[i] && (fpage_reg[i] == q_page);
            empty[i]   = managed[i] && !fvalid_reg[i];
        end
        hit_any   = |match;
        empty_any = |empty;
        hit_idx   = '0;
        empty_idx = '0;
        for (int i = NUM_FRAMES - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit_idx = IDX_W'(i);
            end
            if (empty[i])
            begin
                empty_idx = IDX_W'(i);
            end
        end
        for (int g = 0; g < NUM_GRP; g++)
        begin
            grp_ok[g]   = 1'b0;
            grp_idx[g]  = '0;
            grp_cnt[g]  = '0;
            grp_page[g] = '0;
            for (int j = 0; j < GRP_SIZE; j++)
            begin
                k = g * GRP_SIZE + j;
                if (k < NUM_FRAMES)
                begin
                    if (managed[k] && (!grp_ok[g] || (fuses_reg[k] > grp_cnt[g])))
                    begin
                        grp_ok[g]   = 1'b1;
                        grp_idx[g]  = IDX_W'(k);
                        grp_cnt[g]  = fuses_reg[k];
                        grp_page[g] = fpage_reg[k];
                    end
                end
            end
        end
    end

    // update step: final max over groups, select frame, build result
    always_comb
    begin
        best_ok     = 1'b0;
        victim_idx  = '0;
        best_cnt    = '0;
        victim_page = '0;
        for (int g = 0; g < NUM_GRP; g++)
        begin
            if (grp_ok_reg[g] && (!best_ok || (grp_cnt_reg[g] > best_cnt)))
            begin
                best_ok     = 1'b1;
                victim_idx  = grp_idx_reg[g];
                best_cnt    = grp_cnt_reg[g];
                victim_page = grp_page_reg[g];
            end
        end

        evict   = !hit_reg && !empty_any_reg;
        cnt_inc = hit_cnt_reg + ((hit_cnt_reg != COUNT_MAX) ? COUNT_W'(1) : COUNT_W'(0));

        if (hit_reg)
        begin
            sel = hit_idx_reg;
        end
        else if (empty_any_reg)
        begin
            sel = empty_idx_reg;
        end
        else
        begin
            sel = victim_idx;
        end

        if (!hit_reg && (fault_reg != COUNT_MAX))
        begin
            fault_next = fault_reg + COUNT_W'(1);
        end
        else
        begin
            fault_next = fault_reg;
        end

        out_next.hit           = hit_reg;
        out_next.frame_index   = FRAME_W'(sel);
        out_next.evicted_valid = evict;
        out_next.evicted_page  = evict ? PAGE_W'(victim_page) : '0;
        out_next.use_count     = hit_reg ? cnt_inc : COUNT_W'(1);
        out_next.fault_total   = fault_next;
    end

    assign look   = (state_reg == ST_LOOK) && q_valid;
    assign q_pop  = look;
    assign commit = (state_reg == ST_DO) && (!out_valid_reg || rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOOK;
            cfg_reg       <= CFG_RESET;
            fvalid_reg    <= '0;
            fault_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                cfg_reg <= cfg.frames_in_use;
            end
            unique case (state_reg)
                ST_LOOK:
                begin
                    if (look)
                    begin
                        state_reg <= ST_DO;
                    end
                end
                ST_DO:
                begin
                    if (commit)
                    begin
                        state_reg <= ST_LOOK;
                    end
                end
                default:
                begin
                    state_reg <= ST_LOOK;
                end
            endcase
            if (commit)
            begin
                out_valid_reg   <= 1'b1;
                fault_reg       <= fault_next;
                fvalid_reg[sel] <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (look)
        begin
            req_page_reg  <= q_page;
            hit_reg       <= hit_any;
            hit_idx_reg   <= hit_idx;
            hit_cnt_reg   <= fuses_reg[hit_idx];
            empty_any_reg <= empty_any;
            empty_idx_reg <= empty_idx;
            for (int g = 0; g < NUM_GRP; g++)
            begin
                grp_ok_reg[g]   <= grp_ok[g];
                grp_idx_reg[g]  <= grp_idx[g];
                grp_cnt_reg[g]  <= grp_cnt[g];
                grp_page_reg[g] <= grp_page[g];
            end
        end
        if (commit)
        begin
            out_reg <= out_next;
            if (hit_reg)
            begin
                fuses_reg[sel] <= cnt_inc;
            end
            else
            begin
                fuses_reg[sel] <= COUNT_W'(1);
                fpage_reg[sel] <= req_page_reg;
            end
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.hit           = out_reg.hit;
    assign rsp.frame_index   = out_reg.frame_index;
    assign rsp.evicted_valid = out_reg.evicted_valid;
    assign rsp.evicted_page  = out_reg.evicted_page;
    assign rsp.use_count     = out_reg.use_count;
    assign rsp.fault_total   = out_reg.fault_total;

endmodule

`default_nettype wire

@@ sv/mfu_page_replacement_top.sv @@
// Top level of the MFU page replacement block: request queue front end and
// table back end. Depends on mfu_pkg, mfu_if, mfu_front, mfu_back.
`timescale 1ns / 1ps
`default_nettype none

// Most-frequently-used page replacement over NUM_FRAMES frames, of which the
// lowest frames_in_use (clamped to 1..NUM_FRAMES) are managed. Each request
// beat yields one result beat, in order. The back end does a lookup step
// (parallel tag compare, first-empty search, per-group count maximum), then
// an update step (final maximum, table write, result register load) that
// stalls while a held result is not taken; it takes no new request until the
// update is done. A two-beat queue in front takes requests while the back end
// works or waits on a stalled result. The frame table is empty after reset
// with no clearing time. The user must write frames_in_use through cfg only
// while no request is in flight; the block does not check this.

module mfu_page_replacement_top import mfu_pkg::*; #(
    parameter int NUM_FRAMES = 16,
    parameter int PAGE_BITS  = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    mfu_req_if.sink   req,
    mfu_rsp_if.source rsp,
    mfu_cfg_if.sink   cfg
);

    logic                 q_valid;
    logic [PAGE_BITS-1:0] q_page;
    logic                 q_pop;

    mfu_front #(
        .PAGE_BITS (PAGE_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .q_valid (q_valid),
        .q_page  (q_page),
        .q_pop   (q_pop)
    );

    mfu_back #(
        .NUM_FRAMES (NUM_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_page  (q_page),
        .q_pop   (q_pop),
        .cfg     (cfg),
        .rsp     (rsp)
    );

endmodule

`default_nettype wire
